### rtl/sgr_pkg.sv
// shared types, constants and the 5x7 glyph rom for the scaled glyph rasterizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sgr_pkg;

    localparam int GLYPH_COLS  = 5;
    localparam int ROW_SLOTS   = 8;
    localparam int GLYPH_BITS  = GLYPH_COLS * ROW_SLOTS;
    localparam int BIT_IDX_W   = $clog2(GLYPH_BITS);
    localparam int MAX_SCALE   = 15;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;

    localparam logic [5:0] IDX_SPACE  = 6'd10;
    localparam logic [5:0] IDX_ALPHA  = 6'd11;
    localparam logic [5:0] IDX_QMARK  = 6'd37;
    localparam logic [5:0] GLYPH_NONE = 6'd63;

    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  char_code;
        logic [15:0] pixel_color;
        logic [3:0]  scale_factor;
    } req_t;

    typedef struct packed {
        logic [15:0] square_x;
        logic [15:0] square_y;
        logic [3:0]  square_size;
        logic [15:0] square_color;
        logic        last_square;
    } square_t;

    // classified request waiting for the back end
    typedef struct packed {
        logic [15:0]           ox;
        logic [15:0]           oy;
        logic [15:0]           color;
        logic [3:0]            scale;
        logic [GLYPH_BITS-1:0] dots;
    } glyph_entry_t;

    // front end control toward the queue
    typedef struct packed {
        logic push;
    } front_ctl_t;

    // column bytes packed so column c sits at bits [c*8 +: 8]
    function automatic logic [GLYPH_BITS-1:0] cols(
        input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
        input logic [7:0] c3, input logic [7:0] c4);
        cols = {c4, c3, c2, c1, c0};
    endfunction

    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [5:0] gi;
        gi = GLYPH_NONE;
        if (code >= CHAR_0 && code <= CHAR_9)
            gi = 6'(code - CHAR_0);
        else if (code == CHAR_SPACE)
            gi = IDX_SPACE;
        else if (code >= CHAR_A && code <= CHAR_Z)
            gi = 6'(code - CHAR_A) + IDX_ALPHA;
        else if (code == CHAR_QMARK)
            gi = IDX_QMARK;
        return gi;
    endfunction

    // unsupported codes and space both give an empty dot map
    function automatic logic [GLYPH_BITS-1:0] glyph_dots(input logic [7:0] code);
        logic [GLYPH_BITS-1:0] g;
        case (glyph_index(code))
            6'd0:  g = cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            6'd1:  g = cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            6'd2:  g = cols(8'h62, 8'h51, 8'h49, 8'h49, 8'h46);
            6'd3:  g = cols(8'h22, 8'h49, 8'h49, 8'h49, 8'h36);
            6'd4:  g = cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            6'd5:  g = cols(8'h2F, 8'h49, 8'h49, 8'h49, 8'h31);
            6'd6:  g = cols(8'h3E, 8'h49, 8'h49, 8'h49, 8'h30);
            6'd7:  g = cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            6'd8:  g = cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            6'd9:  g = cols(8'h06, 8'h49, 8'h49, 8'h49, 8'h3E);
            6'd11: g = cols(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
            6'd12: g = cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            6'd13: g = cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            6'd14: g = cols(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            6'd15: g = cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            6'd16: g = cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            6'd17: g = cols(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
            6'd18: g = cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            6'd19: g = cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            6'd20: g = cols(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            6'd21: g = cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            6'd22: g = cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            6'd23: g = cols(8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F);
            6'd24: g = cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            6'd25: g = cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            6'd26: g = cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            6'd27: g = cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            6'd28: g = cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            6'd29: g = cols(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            6'd30: g = cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            6'd31: g = cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            6'd32: g = cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            6'd33: g = cols(8'h7F, 8'h20, 8'h10, 8'h20, 8'h7F);
            6'd34: g = cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            6'd35: g = cols(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
            6'd36: g = cols(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            6'd37: g = cols(8'h02, 8'h01, 8'h59, 8'h06, 8'h00);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### rtl/sgr_front.sv
// front end: accepts draw requests, saturates the scale and looks up the glyph
// depends on sgr_pkg; feeds sgr_queue
`timescale 1ns / 1ps

module sgr_front (
    input  logic                 req_valid,
    output logic                 req_stall,
    input  sgr_pkg::req_t        req,
    input  logic                 q_full,
    output sgr_pkg::front_ctl_t  ctl,
    output sgr_pkg::glyph_entry_t entry
);
    import sgr_pkg::*;

    logic [3:0]            scale_eff;
    logic [GLYPH_BITS-1:0] dots;

    always_comb
    begin
        if ({4'd0, req.scale_factor} > 8'(MAX_SCALE))
            scale_eff = 4'(MAX_SCALE);
        else
            scale_eff = req.scale_factor;
        dots = glyph_dots(req.char_code);
    end

    assign entry.ox    = req.origin_x;
    assign entry.oy    = req.origin_y;
    assign entry.color = req.pixel_color;
    assign entry.scale = scale_eff;
    assign entry.dots  = dots;

    // empty requests are taken and dropped here
    assign req_stall = q_full;
    assign ctl.push  = req_valid && !q_full && (dots != '0) && (scale_eff != 4'd0);

endmodule

### rtl/sgr_queue.sv
// short register queue between front and back end
// depends on sgr_pkg for the entry type
`timescale 1ns / 1ps

module sgr_queue #(
    parameter int DEPTH = sgr_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sgr_pkg::glyph_entry_t wdata,
    output logic                  full,
    input  logic                  pop,
    output sgr_pkg::glyph_entry_t rdata,
    output logic                  nonempty
);
    import sgr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    glyph_entry_t     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        return p + PTR_W'(1);
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/sgr_back.sv
// back end: walks the set dots of one glyph and emits one square per cycle unless stalled
// depends on sgr_pkg; reads entries from sgr_queue
`timescale 1ns / 1ps

module sgr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_nonempty,
    input  sgr_pkg::glyph_entry_t q_data,
    output logic                  q_pop,
    output logic                  sq_valid,
    input  logic                  sq_stall,
    output sgr_pkg::square_t      sq
);
    import sgr_pkg::*;

    glyph_entry_t          cur_reg, cur_next;
    logic [GLYPH_BITS-1:0] mask_reg, mask_next;
    logic                  busy_reg, busy_next;
    logic                  valid_reg, valid_next;
    square_t               out_reg, out_next;

    logic [GLYPH_BITS-1:0] low_bit;
    logic [GLYPH_BITS-1:0] rest;
    logic [BIT_IDX_W-1:0]  bit_idx;
    logic [2:0]            col;
    logic [2:0]            row;
    logic [6:0]            dx;
    logic [6:0]            dy;
    logic                  emit;
    logic                  load;

    // lowest remaining dot is the next one in column-major order
    always_comb
    begin
        low_bit = mask_reg & (~mask_reg + GLYPH_BITS'(1));
        rest    = mask_reg & (mask_reg - GLYPH_BITS'(1));
        bit_idx = '0;
        for (int i = 0; i < GLYPH_BITS; i++)
        begin
            if (low_bit[i])
                bit_idx = bit_idx | BIT_IDX_W'(i);
        end
        col = bit_idx[5:3];
        row = bit_idx[2:0];
        dx  = 7'(col) * 7'(cur_reg.scale);
        dy  = 7'(row) * 7'(cur_reg.scale);
    end

    assign emit  = busy_reg && (!valid_reg || !sq_stall);
    assign load  = q_nonempty && (!busy_reg || (emit && rest == '0));
    assign q_pop = load;

    always_comb
    begin
        cur_next   = cur_reg;
        mask_next  = mask_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (valid_reg && !sq_stall)
            valid_next = 1'b0;
        if (emit)
        begin
            out_next.square_x     = cur_reg.ox + 16'(dx);
            out_next.square_y     = cur_reg.oy + 16'(dy);
            out_next.square_size  = cur_reg.scale;
            out_next.square_color = cur_reg.color;
            out_next.last_square  = (rest == '0);
            valid_next            = 1'b1;
            mask_next             = rest;
            busy_next             = (rest != '0);
        end
        if (load)
        begin
            cur_next  = q_data;
            mask_next = q_data.dots;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    assign sq_valid = valid_reg;
    assign sq       = out_reg;

endmodule

### rtl/scaled_glyph_rasterizer.sv
// top level of the scaled 5x7 glyph rasterizer
// depends on sgr_pkg, sgr_front, sgr_queue and sgr_back
`timescale 1ns / 1ps

// each request draws one character from the built-in 5x7 font (digits,
// space, A-Z, '?') and comes out as one filled square per set dot, in
// column-major order, with the last square of the character flagged; the
// square side is the request scale saturated to MAX_SCALE. the back end
// emits one square per clock while sq_stall is low; a character gives as
// many squares as it has set dots (up to 20, for 'B'); requests that draw
// nothing (unsupported code, space, zero scale) are taken and vanish. the
// front end takes a request in any cycle the queue has room, so the next
// character is accepted while the current one is still drawn, and a square
// waiting in the output register never blocks the input side by itself
module scaled_glyph_rasterizer #(
    parameter int QUEUE_DEPTH = sgr_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    // draw request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  sgr_pkg::req_t      req,
    // square channel
    output logic               sq_valid,
    input  logic               sq_stall,
    output sgr_pkg::square_t   sq
);
    import sgr_pkg::*;

    front_ctl_t   front_ctl;
    glyph_entry_t front_entry;
    glyph_entry_t q_data;
    logic         q_full;
    logic         q_nonempty;
    logic         q_pop;

    // classify: scale saturation and glyph rom lookup
    sgr_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .ctl       (front_ctl),
        .entry     (front_entry)
    );

    // decouples request intake from square emission
    sgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_ctl.push),
        .wdata    (front_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rdata    (q_data),
        .nonempty (q_nonempty)
    );

    // dot scan and square coordinate generation
    sgr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .sq_valid   (sq_valid),
        .sq_stall   (sq_stall),
        .sq         (sq)
    );

endmodule

### rtl/sgr_checker.sv
// port-level checks for the scaled glyph rasterizer square channel
// depends on sgr_pkg; bound to scaled_glyph_rasterizer
`timescale 1ns / 1ps

module sgr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sq_valid,
    input logic             sq_stall,
    input sgr_pkg::square_t sq
);
    import sgr_pkg::*;

    // a stalled square stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid && sq_stall |=> sq_valid)
        else $error("square dropped while stalled");

    // a stalled square keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid && sq_stall |=> $stable(sq))
        else $error("square changed while stalled");

    // zero scale never reaches the output
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> sq.square_size != 4'd0)
        else $error("square of size zero");

    // squares of one character follow without a gap and share size and color
    a_same_char: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid && !sq_stall && !sq.last_square |=>
            sq_valid && sq.square_color == $past(sq.square_color)
            && sq.square_size == $past(sq.square_size))
        else $error("character broken before its last square");

endmodule

bind scaled_glyph_rasterizer sgr_checker u_sgr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .sq_valid (sq_valid),
    .sq_stall (sq_stall),
    .sq       (sq)
);

### tb/sv/scaled_glyph_rasterizer_test.sv
// self-checking testbench for scaled_glyph_rasterizer: directed and random draw requests
// depends on sgr_pkg (request and square types) and the rtl of the block
`timescale 1ns / 1ps

module scaled_glyph_rasterizer_test;

    import sgr_pkg::req_t;
    import sgr_pkg::square_t;

    // run shape
    localparam int RANDOM_PER_MIX = 59;     // four idling mixes, about 260 requests in all
    localparam int HOLD_OFF_CYCLES = 300;   // long output stall that backs up the input
    localparam int TAIL_CYCLES = 40;        // quiet time after the last square
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int MAX_REPORTS = 10;

    // character codes of the font
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    // font slots: digits first, then space, letters and the question mark
    localparam int SLOT_SPACE = 10;
    localparam int SLOT_ALPHA = 11;
    localparam int SLOT_QMARK = SLOT_ALPHA + 26;
    localparam int NO_GLYPH   = -1;
    localparam int FONT_COLS  = 5;
    localparam int FONT_ROWS  = 7;

    // column bytes, column 0 in the top byte; bit r of a column is row r
    localparam logic [39:0] FONT [38] = '{
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h62_51_49_49_46, 40'h22_49_49_49_36,
        40'h18_14_12_7F_10, 40'h2F_49_49_49_31, 40'h3E_49_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_49_3E, 40'h00_00_00_00_00, 40'h7E_11_11_11_7E,
        40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C, 40'h7F_49_49_49_41,
        40'h7F_09_09_09_01, 40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
        40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40, 40'h7F_02_04_02_7F,
        40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06, 40'h3E_41_51_21_5E,
        40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
        40'h1F_20_40_20_1F, 40'h7F_20_10_20_7F, 40'h63_14_08_14_63, 40'h03_04_78_04_03,
        40'h61_51_49_45_43, 40'h02_01_59_06_00
    };

    // font slot of a character code, NO_GLYPH when the font lacks it
    function automatic int font_slot(input logic [7:0] code);
        if (code >= CH_ZERO && code <= CH_NINE) return int'(code - CH_ZERO);
        if (code == CH_SPACE) return SLOT_SPACE;
        if (code >= CH_A && code <= CH_Z) return int'(code - CH_A) + SLOT_ALPHA;
        if (code == CH_QMARK) return SLOT_QMARK;
        return NO_GLYPH;
    endfunction

    // squares expected from the block, in drawing order
    class square_scoreboard;
        square_t expected[$];
        int failures;
        int reported;
        int requests;
        int blank_requests;
        int squares;

        function new();
            failures = 0;
            reported = 0;
            requests = 0;
            blank_requests = 0;
            squares = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // expand one accepted request into its squares, column by column
        function void note_request(input req_t r);
            int slot;
            int n;
            logic [3:0] side;
            logic [7:0] column;
            square_t held;

            requests++;
            slot = font_slot(r.char_code);
            side = (int'(r.scale_factor) > sgr_pkg::MAX_SCALE) ?
                   4'(sgr_pkg::MAX_SCALE) : r.scale_factor;
            n = 0;
            held = '0;
            if (slot != NO_GLYPH && side != 4'd0) begin
                for (int c = 0; c < FONT_COLS; c++) begin
                    column = FONT[slot][39 - 8 * c -: 8];
                    for (int row = 0; row < FONT_ROWS; row++) begin
                        if (column[row]) begin
                            if (n > 0) expected.push_back(held);
                            held.square_x = r.origin_x + 16'(c) * 16'(side);
                            held.square_y = r.origin_y + 16'(row) * 16'(side);
                            held.square_size = side;
                            held.square_color = r.pixel_color;
                            held.last_square = 1'b0;
                            n++;
                        end
                    end
                end
            end
            if (n > 0) begin
                held.last_square = 1'b1;
                expected.push_back(held);
            end else begin
                blank_requests++;
            end
        endfunction

        function void check_square(input square_t got);
            square_t want;
            if (expected.size() == 0) begin
                failures++;
                if (reported < MAX_REPORTS)
                    $display("unexpected square x=%h y=%h size=%h color=%h last=%b",
                             got.square_x, got.square_y, got.square_size,
                             got.square_color, got.last_square);
                reported++;
                return;
            end
            want = expected.pop_front();
            squares++;
            if (got.square_x !== want.square_x || got.square_y !== want.square_y ||
                got.square_size !== want.square_size ||
                got.square_color !== want.square_color ||
                got.last_square !== want.last_square) begin
                failures++;
                if (reported < MAX_REPORTS) begin
                    $display("square mismatch: expected x=%h y=%h size=%h color=%h last=%b",
                             want.square_x, want.square_y, want.square_size,
                             want.square_color, want.last_square);
                    $display("                 got      x=%h y=%h size=%h color=%h last=%b",
                             got.square_x, got.square_y, got.square_size,
                             got.square_color, got.last_square);
                end
                reported++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    req_valid;
    logic    req_stall;
    req_t    req;
    logic    sq_valid;
    logic    sq_stall;
    square_t sq;

    square_scoreboard sb;

    // idling mix, percent per cycle, changed by the main sequence between mixes
    int send_idle_pct;
    int recv_stall_pct;
    // one-shot request for a long output hold-off
    bit hold_off_req;
    int quiet_cycles;

    scaled_glyph_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .sq_valid  (sq_valid),
        .sq_stall  (sq_stall),
        .sq        (sq)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // transfers are taken from values sampled before the edge, so the
    // request is noted before any square it might cause in the same cycle
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && !req_stall) sb.note_request(req);
            if (sq_valid && !sq_stall) sb.check_square(sq);
        end
    end

    // watchdog: a run that stops moving for too long is a failure
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (sq_valid && !sq_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // square receiver: random stalls, plus the long hold-off on request;
    // the hold-off is counted here so the sender keeps offering meanwhile
    initial
    begin
        sq_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                sq_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            sq_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic req_t make_request(input logic [15:0] x, input logic [15:0] y,
                                          input logic [7:0] code, input logic [15:0] color,
                                          input logic [3:0] scale);
        req_t r;
        r.origin_x = x;
        r.origin_y = y;
        r.char_code = code;
        r.pixel_color = color;
        r.scale_factor = scale;
        return r;
    endfunction

    // mostly drawable characters, some spaces, some arbitrary codes;
    // a few zero scales so the empty path is hit in every mix
    function automatic req_t random_request();
        int pick;
        int slot;
        logic [7:0] code;
        logic [3:0] scale;

        pick = $urandom_range(99);
        if (pick < 70) begin
            slot = $urandom_range(36);
            if (slot < 10) code = CH_ZERO + 8'(slot);
            else if (slot < 36) code = CH_A + 8'(slot - 10);
            else code = CH_QMARK;
        end else if (pick < 80) begin
            code = CH_SPACE;
        end else begin
            code = 8'($urandom_range(255));
        end
        scale = ($urandom_range(19) == 0) ? 4'd0 : 4'($urandom_range(15, 1));
        return make_request(16'($urandom), 16'($urandom), code, 16'($urandom), scale);
    endfunction

    // hold the request until the block takes it
    task automatic offer_request(input req_t r);
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
    endtask

    // random gap after a request; payload is scrambled while valid is low
    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            req <= req_t'({$urandom, $urandom});
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // sender pauses until every expected square has come out; the first
    // edge lets the monitor note the request taken at the previous one
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic random_mix(input int idle_pct, input int stall_pct, input bit hold);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold) hold_off_req = 1'b1;
        for (int i = 0; i < RANDOM_PER_MIX; i++) begin
            offer_request(random_request());
            sender_gap();
        end
        wait_for_drain();
    endtask

    initial
    begin
        req_t directed[$];

        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = 1'b0;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and wrap-around at the top of the coordinate range
        directed.push_back(make_request(16'h0000, 16'h0000, CH_ZERO, 16'h0000, 4'd1));
        directed.push_back(make_request(16'hFFFF, 16'hFFFF, "W", 16'hFFFF, 4'd15));
        directed.push_back(make_request(16'hFFF0, 16'hFFE0, "8", 16'hA5A5, 4'd15));
        directed.push_back(make_request(16'h7FFF, 16'h8000, CH_NINE, 16'h5A5A, 4'd8));
        directed.push_back(make_request(16'h0001, 16'hFFFE, CH_A, 16'hF800, 4'd2));
        directed.push_back(make_request(16'h1234, 16'h5678, CH_Z, 16'h07E0, 4'd7));
        directed.push_back(make_request(16'hFFFF, 16'h0000, CH_QMARK, 16'h001F, 4'd4));
        directed.push_back(make_request(16'h0000, 16'hFFFF, "M", 16'hFFFF, 4'd15));
        directed.push_back(make_request(16'h00FF, 16'hFF00, "1", 16'h8001, 4'd3));
        // blank glyph: space draws nothing at any scale
        directed.push_back(make_request(16'h0010, 16'h0020, CH_SPACE, 16'hFFFF, 4'd5));
        directed.push_back(make_request(16'hFFFF, 16'hFFFF, CH_SPACE, 16'h0000, 4'd15));
        // zero scale draws nothing even for a full glyph
        directed.push_back(make_request(16'h0100, 16'h0200, "8", 16'h1234, 4'd0));
        directed.push_back(make_request(16'hFFFF, 16'hFFFF, CH_QMARK, 16'hFFFF, 4'd0));
        // codes outside the font: lowercase, neighbors of each range, high codes
        directed.push_back(make_request(16'h0300, 16'h0400, "a", 16'hFFFF, 4'd6));
        directed.push_back(make_request(16'h0300, 16'h0400, 8'h00, 16'hFFFF, 4'd6));
        directed.push_back(make_request(16'h0300, 16'h0400, 8'hFF, 16'hFFFF, 4'd15));
        directed.push_back(make_request(16'h0300, 16'h0400, 8'h80, 16'hFFFF, 4'd1));
        directed.push_back(make_request(16'h0300, 16'h0400, "@", 16'hFFFF, 4'd1));
        directed.push_back(make_request(16'h0300, 16'h0400, "[", 16'hFFFF, 4'd1));
        directed.push_back(make_request(16'h0300, 16'h0400, "/", 16'hFFFF, 4'd1));
        directed.push_back(make_request(16'h0300, 16'h0400, ":", 16'hFFFF, 4'd1));
        directed.push_back(make_request(16'h0300, 16'h0400, ">", 16'hFFFF, 4'd1));
        // a drawable character right after empty ones, then one more extreme
        directed.push_back(make_request(16'h4000, 16'h4000, "I", 16'hC0DE, 4'd9));
        directed.push_back(make_request(16'h8000, 16'h7FFF, "0", 16'h3C3C, 4'd15));

        foreach (directed[i]) offer_request(directed[i]);
        wait_for_drain();

        // no idling, with the long output hold-off at the start so the block
        // backs up and stalls its input while requests keep coming
        random_mix(0, 0, 1'b1);
        // sender mostly idle
        random_mix(83, 0, 1'b0);
        // receiver mostly stalling
        random_mix(0, 83, 1'b0);
        // both sides idling now and then
        random_mix(25, 25, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0) begin
            sb.failures++;
            $display("%0d squares never came out", sb.pending());
        end
        $display("covered %0d draw requests (%0d drawing nothing) and %0d squares,",
                 sb.requests, sb.blank_requests, sb.squares);
        $display("over four idling mixes and a %0d-cycle output hold-off; %0d failures",
                 HOLD_OFF_CYCLES, sb.failures);
        if (sb.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### scaled_glyph_rasterizer.f
rtl/sgr_pkg.sv
rtl/sgr_front.sv
rtl/sgr_queue.sv
rtl/sgr_back.sv
rtl/scaled_glyph_rasterizer.sv
rtl/sgr_checker.sv
tb/sv/scaled_glyph_rasterizer_test.sv
